// ----- hw/rtl/det_pkg.sv -----
// Shared types, codes and default sizes for the directory entry table.
package det_pkg;

    localparam int DEF_SLOT_COUNT  = 32;
    localparam int DEF_NAME_BYTES  = 30;
    localparam int DEF_INODE_BITS  = 16;
    localparam int FULL_NAME_BYTES = 30;
    localparam int FULL_NAME_BITS  = 8 * FULL_NAME_BYTES;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_LIST   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_FOUND  = 3'd1,
        STAT_DUPLICATE  = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_EMPTY_NAME = 3'd4
    } status_t;

    typedef struct packed {
        kind_t        kind;
        logic [63:0]  name_w0;
        logic [63:0]  name_w1;
        logic [63:0]  name_w2;
        logic [47:0]  name_w3;
        logic [15:0]  new_inode;
        logic [5:0]   list_limit;
    } req_item_t;

    typedef struct packed {
        status_t      status;
        logic [4:0]   slot_index;
        logic [15:0]  found_inode;
        logic [63:0]  out_w0;
        logic [63:0]  out_w1;
        logic [63:0]  out_w2;
        logic [47:0]  out_w3;
        logic         last_item;
        logic [5:0]   live_count;
    } rsp_item_t;

endpackage

// ----- hw/rtl/det_mem.sv -----
// Slot storage: one write port and one registered read port.
module det_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= entry_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/det_ctrl.sv -----
// Sequencer; walks slots one per cycle unless a list stalls; one name comparator.
module det_ctrl #(
    parameter int SLOT_COUNT = det_pkg::DEF_SLOT_COUNT,
    parameter int NAME_BYTES = det_pkg::DEF_NAME_BYTES,
    parameter int INODE_BITS = det_pkg::DEF_INODE_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  det_pkg::kind_t                          req_kind,
    input  logic [8*NAME_BYTES-1:0]                 req_key,
    input  logic                                    req_key_empty,
    input  logic [15:0]                             req_inode,
    input  logic [5:0]                              req_limit,
    output logic                                    mem_wr_en,
    output logic [$clog2(SLOT_COUNT)-1:0]           mem_wr_addr,
    output logic [8*NAME_BYTES+INODE_BITS-1:0]      mem_wr_data,
    output logic [$clog2(SLOT_COUNT)-1:0]           mem_rd_addr,
    input  logic [8*NAME_BYTES+INODE_BITS-1:0]      mem_rd_data,
    output logic                                    rsp_valid,
    input  logic                                    rsp_ready,
    output det_pkg::rsp_item_t                      rsp
);

    import det_pkg::*;

    localparam int NAME_W  = 8 * NAME_BYTES;
    localparam int ENTRY_W = NAME_W + INODE_BITS;
    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int CW      = $clog2(SLOT_COUNT + 1);
    localparam int NW      = (CW > 6) ? CW : 6;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // Control state.
    state_t                  state_reg, state_next;
    logic [SLOT_COUNT-1:0]   used_reg, used_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    chk_valid_reg, chk_valid_next;
    logic                    free_found_reg, free_found_next;
    logic                    held_reg, held_next;
    logic [CW-1:0]           n_reg, n_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload.
    kind_t                   kind_reg, kind_next;
    logic [NAME_W-1:0]       key_reg, key_next;
    logic [INODE_BITS-1:0]   inode_reg, inode_next;
    logic [5:0]              limit_reg, limit_next;
    logic [SLOT_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [SLOT_W-1:0]       free_idx_reg, free_idx_next;
    status_t                 res_status_reg, res_status_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic [INODE_BITS-1:0]   res_inode_reg, res_inode_next;
    logic [NAME_W-1:0]       res_name_reg, res_name_next;
    rsp_item_t               out_reg, out_next;

    logic [NAME_W-1:0]       chk_name;
    logic [INODE_BITS-1:0]   chk_inode;
    logic                    chk_used;
    logic                    chk_live;
    logic                    name_hit;
    logic                    scan_done;
    logic                    out_free;
    logic [CW-1:0]           n_plus;
    logic                    limit_hit;

    function automatic rsp_item_t make_rsp(
        input status_t               st,
        input logic [SLOT_W-1:0]     slot,
        input logic [INODE_BITS-1:0] ino,
        input logic [NAME_W-1:0]     nm,
        input logic                  last,
        input logic [CW-1:0]         cnt
    );
        logic [31:0]               slot32;
        logic [31:0]               ino32;
        logic [31:0]               cnt32;
        logic [FULL_NAME_BITS-1:0] nm_full;
        rsp_item_t                 o;
        slot32        = 32'(slot);
        ino32         = 32'(ino);
        cnt32         = 32'(cnt);
        nm_full       = FULL_NAME_BITS'(nm);
        o.status      = st;
        o.slot_index  = slot32[4:0];
        o.found_inode = ino32[15:0];
        o.out_w0      = nm_full[63:0];
        o.out_w1      = nm_full[127:64];
        o.out_w2      = nm_full[191:128];
        o.out_w3      = nm_full[239:192];
        o.last_item   = last;
        o.live_count  = cnt32[5:0];
        return o;
    endfunction

    assign chk_name  = mem_rd_data[ENTRY_W-1:INODE_BITS];
    assign chk_inode = mem_rd_data[INODE_BITS-1:0];
    assign chk_used  = used_reg[chk_idx_reg];
    assign chk_live  = chk_valid_reg && chk_used;
    assign name_hit  = chk_live && (chk_name == key_reg);
    assign scan_done = (scan_idx_reg == CW'(SLOT_COUNT)) && !chk_valid_reg;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign n_plus    = n_reg + CW'(1);
    assign limit_hit = (NW'(n_plus) == NW'(limit_reg));

    assign req_ready   = (state_reg == S_IDLE);
    assign mem_rd_addr = scan_idx_reg[SLOT_W-1:0];
    assign rsp_valid   = out_valid_reg;
    assign rsp         = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        chk_valid_next  = chk_valid_reg;
        free_found_next = free_found_reg;
        held_next       = held_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        inode_next      = inode_reg;
        limit_next      = limit_reg;
        chk_idx_next    = chk_idx_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_inode_next  = res_inode_reg;
        res_name_next   = res_name_reg;
        out_next        = out_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = free_idx_reg;
        mem_wr_data     = {key_reg, inode_reg};

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next       = req_kind;
                    key_next        = req_key;
                    inode_next      = INODE_BITS'(32'(req_inode));
                    limit_next      = req_limit;
                    scan_idx_next   = '0;
                    chk_valid_next  = 1'b0;
                    free_found_next = 1'b0;
                    held_next       = 1'b0;
                    n_next          = '0;
                    res_status_next = STAT_OK;
                    res_slot_next   = '0;
                    res_inode_next  = '0;
                    res_name_next   = '0;
                    if (req_kind != KIND_LIST && req_key_empty)
                    begin
                        res_status_next = (req_kind == KIND_ADD) ? STAT_EMPTY_NAME
                                                                 : STAT_NOT_FOUND;
                        state_next      = S_EMIT;
                    end
                    else if (req_kind == KIND_LIST && req_limit == 6'd0)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // The read issued this cycle is checked in the next one.
                if (scan_idx_reg != CW'(SLOT_COUNT))
                begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[SLOT_W-1:0];
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end

                if (kind_reg == KIND_ADD && chk_valid_reg && !chk_used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end

                if (scan_done)
                begin
                    state_next = S_EMIT;
                    case (kind_reg)
                        KIND_ADD:
                        begin
                            if (free_found_reg)
                            begin
                                mem_wr_en                = 1'b1;
                                used_next[free_idx_reg]  = 1'b1;
                                count_next               = count_reg + CW'(1);
                                res_status_next          = STAT_OK;
                                res_slot_next            = free_idx_reg;
                                res_inode_next           = inode_reg;
                            end
                            else
                            begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        KIND_LIST:
                        begin
                            if (!held_reg)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                    endcase
                end
                else
                begin
                    case (kind_reg)
                        KIND_SEARCH, KIND_DELETE:
                        begin
                            if (name_hit)
                            begin
                                res_status_next = STAT_OK;
                                res_slot_next   = chk_idx_reg;
                                res_inode_next  = chk_inode;
                                if (kind_reg == KIND_DELETE)
                                begin
                                    used_next[chk_idx_reg] = 1'b0;
                                    count_next             = count_reg - CW'(1);
                                end
                                state_next = S_EMIT;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (name_hit)
                            begin
                                res_status_next = STAT_DUPLICATE;
                                state_next      = S_EMIT;
                            end
                        end
                        default:
                        begin
                            if (chk_live)
                            begin
                                if (!held_reg || out_free)
                                begin
                                    // A held entry is known not to be the last once
                                    // another occupied slot turns up.
                                    if (held_reg)
                                    begin
                                        out_next = make_rsp(STAT_OK, res_slot_reg,
                                                            res_inode_reg, res_name_reg,
                                                            1'b0, count_reg);
                                        out_valid_next = 1'b1;
                                    end
                                    held_next       = 1'b1;
                                    res_status_next = STAT_OK;
                                    res_slot_next   = chk_idx_reg;
                                    res_inode_next  = chk_inode;
                                    res_name_next   = chk_name;
                                    n_next          = n_plus;
                                    if (limit_hit)
                                    begin
                                        state_next = S_EMIT;
                                    end
                                end
                                else
                                begin
                                    // Output still full: read this slot again later.
                                    scan_idx_next  = CW'(chk_idx_reg);
                                    chk_valid_next = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next = make_rsp(res_status_reg, res_slot_reg, res_inode_reg,
                                        res_name_reg, 1'b1, count_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            held_reg       <= 1'b0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            chk_valid_reg  <= chk_valid_next;
            free_found_reg <= free_found_next;
            held_reg       <= held_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        inode_reg      <= inode_next;
        limit_reg      <= limit_next;
        chk_idx_reg    <= chk_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_inode_reg  <= res_inode_next;
        res_name_reg   <= res_name_next;
        out_reg        <= out_next;
    end

endmodule

// ----- hw/rtl/directory_entry_table.sv -----
// Directory entry table: name normalization, slot sequencer and slot storage.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------
//   request | req_valid, req_ready | req (kind, name, inode, limit)
//   result  | rsp_valid, rsp_ready | rsp (status, slot, inode, name)
//
// A search or delete that misses, and an add that is not a duplicate, read every slot
// before they present the result (one slot read per cycle through the single read
// port); a hit answers sooner, and an empty name outside a list or a zero list limit
// skips the scan. req_ready is high whenever no operation is in progress. A stalled
// result holds in the output register; a list rereads the current slot until it frees.
// Reset clears occupancy.
module directory_entry_table #(
    parameter int SLOT_COUNT = det_pkg::DEF_SLOT_COUNT,
    parameter int NAME_BYTES = det_pkg::DEF_NAME_BYTES,
    parameter int INODE_BITS = det_pkg::DEF_INODE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  det_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output det_pkg::rsp_item_t rsp
);

    import det_pkg::*;

    localparam int NAME_W  = 8 * NAME_BYTES;
    localparam int ENTRY_W = NAME_W + INODE_BITS;
    localparam int SLOT_W  = $clog2(SLOT_COUNT);

    logic [FULL_NAME_BITS-1:0] raw_name;
    logic [NAME_W-1:0]         key;
    logic                      key_empty;
    logic                      mem_wr_en;
    logic [SLOT_W-1:0]         mem_wr_addr;
    logic [ENTRY_W-1:0]        mem_wr_data;
    logic [SLOT_W-1:0]         mem_rd_addr;
    logic [ENTRY_W-1:0]        mem_rd_data;

    assign raw_name  = {req.name_w3, req.name_w2, req.name_w1, req.name_w0};
    assign key_empty = (raw_name[7:0] == 8'd0);

    // Bytes after the first NUL, and past the name length, count as zero.
    always_comb
    begin
        logic alive;
        alive = 1'b1;
        key   = '0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (alive)
            begin
                key[8*i +: 8] = raw_name[8*i +: 8];
            end
            if (raw_name[8*i +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
        end
    end

    det_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .NAME_BYTES (NAME_BYTES),
        .INODE_BITS (INODE_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_kind      (req.kind),
        .req_key       (key),
        .req_key_empty (key_empty),
        .req_inode     (req.new_inode),
        .req_limit     (req.list_limit),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp)
    );

    det_mem #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
